// ===== src/gpv_pkg.sv =====
// ----------------------------------------------------------------------------
// gpv_pkg
// shared types, header offsets and helpers for the gpt header validator
// ----------------------------------------------------------------------------
package gpv_pkg;

  // limits applied to the header fields
  localparam int unsigned MAX_BLOCK_BYTES = 4096;
  localparam int unsigned MAX_ENTRIES     = 512;
  localparam int unsigned MAX_ENTRY_BYTES = 512;

  localparam int unsigned OFFSET_W   = 13;
  localparam int unsigned BLKSIZE_W  = 13;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  // "EFI PART", little-endian
  localparam logic [31:0] SIG_LO = 32'h2049_4645;
  localparam logic [31:0] SIG_HI = 32'h5452_4150;

  localparam logic [31:0] MIN_HEADER = 32'd92;
  localparam logic [31:0] MIN_STRIDE = 32'd128;

  localparam logic [OFFSET_W-1:0] OFF_HSIZE  = 13'h00C;
  localparam logic [OFFSET_W-1:0] OFF_HCRC   = 13'h010;
  localparam logic [OFFSET_W-1:0] OFF_MYLBA  = 13'h018;
  localparam logic [OFFSET_W-1:0] OFF_ELBA   = 13'h048;
  localparam logic [OFFSET_W-1:0] OFF_ECOUNT = 13'h050;
  localparam logic [OFFSET_W-1:0] OFF_ESIZE  = 13'h054;
  localparam logic [OFFSET_W-1:0] OFF_ECRC   = 13'h058;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 13'h1FFF;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // register index, taken from paddr[3]
  typedef enum logic {
    REG_SECTOR_BYTES = 1'b0,
    REG_EXPECTED_LBA = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    FAIL_NONE      = 3'd0,
    FAIL_SIGNATURE = 3'd1,
    FAIL_SIZE      = 3'd2,
    FAIL_LBA       = 3'd3,
    FAIL_CHECKSUM  = 3'd4,
    FAIL_STRIDE    = 3'd5,
    FAIL_COUNT     = 3'd6
  } fail_reason_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic         header_valid;
    fail_reason_t fail_reason;
    logic [63:0]  array_lba;
    logic [31:0]  entry_count;
    logic [31:0]  entry_stride;
    logic [31:0]  array_crc;
  } result_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // expected signature byte at offset 0..7
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [63:0] sig;
    sig = {SIG_HI, SIG_LO};
    return sig[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== src/gpv_stream_if.sv =====
// ----------------------------------------------------------------------------
// gpv_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface gpv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/gpt_header_validator_top.sv =====
// ----------------------------------------------------------------------------
// gpt_header_validator_top
// checks a gpt header block streamed one byte per beat, one verdict per block
// ----------------------------------------------------------------------------
// path: the block's last byte is held in the input register, then loaded into
//   the result register as soon as the input register can advance
// throughput: one byte per cycle, set by the byte-wide crc step in the
//   update stage; a last byte waits only while an earlier verdict is unread
// reset: rst (synchronous) restores a sector size of 512 and expected_lba 1
//   and clears the per-block state and the input and result valid flags
// ----------------------------------------------------------------------------
module gpt_header_validator_top #(
  parameter int unsigned MAX_BLOCK_BYTES = gpv_pkg::MAX_BLOCK_BYTES,
  parameter int unsigned MAX_ENTRIES     = gpv_pkg::MAX_ENTRIES,
  parameter int unsigned MAX_ENTRY_BYTES = gpv_pkg::MAX_ENTRY_BYTES
) (
  input  logic                               clk,
  input  logic                               rst,
  gpv_stream_if.sink                         bytes,
  gpv_stream_if.source                       verdict,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gpv_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gpv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gpv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  // ---------------------------------------------------------------- config
  logic [gpv_pkg::BLKSIZE_W-1:0] sector_bytes;
  logic [63:0]                   expected_lba;
  gpv_pkg::reg_idx_t             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = gpv_pkg::reg_idx_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_bytes <= 13'd512;
      expected_lba <= 64'd1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        gpv_pkg::REG_SECTOR_BYTES: sector_bytes <= pwdata[gpv_pkg::BLKSIZE_W-1:0];
        gpv_pkg::REG_EXPECTED_LBA: expected_lba <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gpv_pkg::REG_SECTOR_BYTES:
        prdata = {{(gpv_pkg::APB_DATA_W-gpv_pkg::BLKSIZE_W){1'b0}}, sector_bytes};
      gpv_pkg::REG_EXPECTED_LBA: prdata = expected_lba;
      default: prdata = '0;
    endcase
  end

  // ------------------------------------------------------- input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;

  // the byte stage only stalls when it holds a last byte and the
  // result register is still full
  assign advance     = in_valid && !(in_last && verdict.valid && !verdict.ready);
  assign bytes.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      in_byte <= bytes.payload.data_byte;
      in_last <= bytes.payload.last_byte;
    end
  end

  // ----------------------------------------------------- per-block state
  logic [gpv_pkg::OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic [31:0]                  crc_running, crc_running_next;
  logic                         signature_match, signature_match_next;
  logic [31:0]                  header_length, header_length_next;
  logic [31:0]                  stored_header_crc, stored_header_crc_next;
  logic [63:0]                  own_lba, own_lba_next;
  logic [63:0]                  array_lba, array_lba_next;
  logic [31:0]                  entry_count, entry_count_next;
  logic [31:0]                  entry_stride, entry_stride_next;
  logic [31:0]                  array_crc, array_crc_next;

  logic        in_hcrc;
  logic        crc_take;
  logic [31:0] limit;
  logic        fields_out;
  gpv_pkg::fail_reason_t reason;
  gpv_pkg::result_t      res;

  always_comb begin
    header_length_next     = header_length;
    stored_header_crc_next = stored_header_crc;
    own_lba_next           = own_lba;
    array_lba_next         = array_lba;
    entry_count_next       = entry_count;
    entry_stride_next      = entry_stride;
    array_crc_next         = array_crc;

    // byte lane capture of the little-endian fields
    for (int k = 0; k < 4; k++) begin
      if (byte_offset == gpv_pkg::OFF_HSIZE + 13'(k))
        header_length_next[8*k +: 8] = in_byte;
      if (byte_offset == gpv_pkg::OFF_HCRC + 13'(k))
        stored_header_crc_next[8*k +: 8] = in_byte;
      if (byte_offset == gpv_pkg::OFF_ECOUNT + 13'(k))
        entry_count_next[8*k +: 8] = in_byte;
      if (byte_offset == gpv_pkg::OFF_ESIZE + 13'(k))
        entry_stride_next[8*k +: 8] = in_byte;
      if (byte_offset == gpv_pkg::OFF_ECRC + 13'(k))
        array_crc_next[8*k +: 8] = in_byte;
    end
    for (int k = 0; k < 8; k++) begin
      if (byte_offset == gpv_pkg::OFF_MYLBA + 13'(k))
        own_lba_next[8*k +: 8] = in_byte;
      if (byte_offset == gpv_pkg::OFF_ELBA + 13'(k))
        array_lba_next[8*k +: 8] = in_byte;
    end

    // signature compare over the first eight bytes
    signature_match_next = signature_match;
    if (byte_offset < 13'd8 && gpv_pkg::sig_byte(byte_offset[2:0]) != in_byte)
      signature_match_next = 1'b0;

    // crc covers the header; the stored checksum goes in as zeros.
    // header_length is complete before the first offset that depends on it
    in_hcrc  = byte_offset >= gpv_pkg::OFF_HCRC &&
               byte_offset <  gpv_pkg::OFF_HCRC + 13'd4;
    crc_take = byte_offset < gpv_pkg::OFF_HCRC + 13'd4 ||
               {19'd0, byte_offset} < header_length;
    crc_running_next = crc_take ?
        gpv_pkg::crc_step(crc_running, in_hcrc ? 8'd0 : in_byte) : crc_running;

    // offset saturates at the top
    if (byte_offset != gpv_pkg::OFFSET_MAX)
      byte_offset_next = byte_offset + 13'd1;
    else
      byte_offset_next = byte_offset;

    // verdict, first failing check wins
    limit = ({19'd0, sector_bytes} < 32'(MAX_BLOCK_BYTES)) ?
            {19'd0, sector_bytes} : 32'(MAX_BLOCK_BYTES);

    if (!signature_match_next || byte_offset < 13'd7)
      reason = gpv_pkg::FAIL_SIGNATURE;
    else if (header_length_next < gpv_pkg::MIN_HEADER || header_length_next > limit)
      reason = gpv_pkg::FAIL_SIZE;
    else if (own_lba_next != expected_lba)
      reason = gpv_pkg::FAIL_LBA;
    else if (~crc_running_next != stored_header_crc_next)
      reason = gpv_pkg::FAIL_CHECKSUM;
    else if (entry_stride_next < gpv_pkg::MIN_STRIDE ||
             entry_stride_next > 32'(MAX_ENTRY_BYTES))
      reason = gpv_pkg::FAIL_STRIDE;
    else if (entry_count_next == 32'd0 ||
             entry_count_next > 32'(MAX_ENTRIES))
      reason = gpv_pkg::FAIL_COUNT;
    else
      reason = gpv_pkg::FAIL_NONE;

    // early failures report no entry-array fields
    fields_out = reason == gpv_pkg::FAIL_NONE || reason == gpv_pkg::FAIL_STRIDE ||
                 reason == gpv_pkg::FAIL_COUNT;

    res.header_valid = reason == gpv_pkg::FAIL_NONE;
    res.fail_reason  = reason;
    res.array_lba    = fields_out ? array_lba_next    : 64'd0;
    res.entry_count  = fields_out ? entry_count_next  : 32'd0;
    res.entry_stride = fields_out ? entry_stride_next : 32'd0;
    res.array_crc    = fields_out ? array_crc_next    : 32'd0;
  end

  // state update; a last byte returns everything to the start-of-block values
  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      byte_offset       <= '0;
      crc_running       <= gpv_pkg::CRC_INIT;
      signature_match   <= 1'b1;
      header_length     <= '0;
      stored_header_crc <= '0;
      own_lba           <= '0;
      array_lba         <= '0;
      entry_count       <= '0;
      entry_stride      <= '0;
      array_crc         <= '0;
    end else if (advance) begin
      byte_offset       <= byte_offset_next;
      crc_running       <= crc_running_next;
      signature_match   <= signature_match_next;
      header_length     <= header_length_next;
      stored_header_crc <= stored_header_crc_next;
      own_lba           <= own_lba_next;
      array_lba         <= array_lba_next;
      entry_count       <= entry_count_next;
      entry_stride      <= entry_stride_next;
      array_crc         <= array_crc_next;
    end
  end

  // ------------------------------------------------------ result register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (advance && in_last) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      verdict.payload <= res;
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for gpt_header_validator_top: streams header blocks
// byte by byte, predicts each verdict and compares it field by field
// ----------------------------------------------------------------------------

// running picture of the block being received, and the verdicts still owed
class header_verdicts;
  logic [12:0] cfg_sector_bytes;
  logic [63:0] cfg_lba;

  logic [12:0] offset;
  logic [31:0] crc;
  bit          sig_ok;
  logic [31:0] hlen;
  logic [31:0] hcrc;
  logic [63:0] own_lba;
  logic [63:0] elba;
  logic [31:0] ecount;
  logic [31:0] estride;
  logic [31:0] ecrc;

  gpv_pkg::result_t verdicts_owed[$];
  int unsigned errors;
  int unsigned compared;
  int unsigned by_reason[8];

  function new();
    cfg_sector_bytes = 13'd512;
    cfg_lba          = 64'd1;
    errors           = 0;
    compared         = 0;
    foreach (by_reason[i]) by_reason[i] = 0;
    clear_block();
  endfunction

  function void clear_block();
    offset  = '0;
    crc     = 32'hFFFF_FFFF;
    sig_ok  = 1'b1;
    hlen    = '0;
    hcrc    = '0;
    own_lba = '0;
    elba    = '0;
    ecount  = '0;
    estride = '0;
    ecrc    = '0;
  endfunction

  // reflected crc-32, one byte, lsb first
  static function logic [31:0] crc_feed(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 32'hEDB8_8320;
      else c = c >> 1;
    end
    return c;
  endfunction

  // drop byte b into a little-endian field of n bytes starting at base
  static function logic [63:0] lane(logic [63:0] v, logic [12:0] o, logic [12:0] base,
                                    int unsigned n, logic [7:0] b);
    if (o >= base && o < base + n) v[8*(o-base) +: 8] = b;
    return v;
  endfunction

  function void set_reg(gpv_pkg::reg_idx_t idx, logic [63:0] v);
    if (idx == gpv_pkg::REG_SECTOR_BYTES) cfg_sector_bytes = v[12:0];
    else cfg_lba = v;
  endfunction

  function void take_byte(gpv_pkg::in_item_t it);
    logic [7:0]           b;
    logic [12:0]          o;
    logic [63:0]          sig;
    int unsigned          limit;
    gpv_pkg::fail_reason_t why;
    gpv_pkg::result_t     r;
    bit                   keep;
    b   = it.data_byte;
    o   = offset;
    sig = {gpv_pkg::SIG_HI, gpv_pkg::SIG_LO};
    if (o < 8 && sig[8*o +: 8] != b) sig_ok = 1'b0;
    hlen    = 32'(lane(64'(hlen), o, gpv_pkg::OFF_HSIZE, 4, b));
    hcrc    = 32'(lane(64'(hcrc), o, gpv_pkg::OFF_HCRC, 4, b));
    own_lba = lane(own_lba, o, gpv_pkg::OFF_MYLBA, 8, b);
    elba    = lane(elba, o, gpv_pkg::OFF_ELBA, 8, b);
    ecount  = 32'(lane(64'(ecount), o, gpv_pkg::OFF_ECOUNT, 4, b));
    estride = 32'(lane(64'(estride), o, gpv_pkg::OFF_ESIZE, 4, b));
    ecrc    = 32'(lane(64'(ecrc), o, gpv_pkg::OFF_ECRC, 4, b));
    // stored checksum bytes count as zero
    if (o < gpv_pkg::OFF_HCRC + 4 || o < hlen) begin
      if (o >= gpv_pkg::OFF_HCRC && o < gpv_pkg::OFF_HCRC + 4) crc = crc_feed(crc, 8'h00);
      else crc = crc_feed(crc, b);
    end
    if (!it.last_byte) begin
      if (o < gpv_pkg::OFFSET_MAX) offset = o + 13'd1;
      return;
    end
    limit = (cfg_sector_bytes < gpv_pkg::MAX_BLOCK_BYTES) ? cfg_sector_bytes
                                                          : gpv_pkg::MAX_BLOCK_BYTES;
    if (!sig_ok || o < 7) why = gpv_pkg::FAIL_SIGNATURE;
    else if (hlen < gpv_pkg::MIN_HEADER || hlen > limit) why = gpv_pkg::FAIL_SIZE;
    else if (own_lba != cfg_lba) why = gpv_pkg::FAIL_LBA;
    else if (~crc != hcrc) why = gpv_pkg::FAIL_CHECKSUM;
    else if (estride < gpv_pkg::MIN_STRIDE || estride > gpv_pkg::MAX_ENTRY_BYTES)
      why = gpv_pkg::FAIL_STRIDE;
    else if (ecount == 0 || ecount > gpv_pkg::MAX_ENTRIES) why = gpv_pkg::FAIL_COUNT;
    else why = gpv_pkg::FAIL_NONE;
    keep = (why == gpv_pkg::FAIL_NONE || why == gpv_pkg::FAIL_STRIDE ||
            why == gpv_pkg::FAIL_COUNT);
    r.header_valid = (why == gpv_pkg::FAIL_NONE);
    r.fail_reason  = why;
    r.array_lba    = keep ? elba : '0;
    r.entry_count  = keep ? ecount : '0;
    r.entry_stride = keep ? estride : '0;
    r.array_crc    = keep ? ecrc : '0;
    verdicts_owed.push_back(r);
    clear_block();
  endfunction

  function void check_verdict(gpv_pkg::result_t got);
    gpv_pkg::result_t want;
    compared++;
    if (verdicts_owed.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("verdict %0d arrived with none owed: valid=%0b reason=%0d",
                 compared, got.header_valid, got.fail_reason);
      return;
    end
    want = verdicts_owed.pop_front();
    by_reason[want.fail_reason]++;
    if (got.header_valid !== want.header_valid || got.fail_reason !== want.fail_reason ||
        got.array_lba !== want.array_lba || got.entry_count !== want.entry_count ||
        got.entry_stride !== want.entry_stride || got.array_crc !== want.array_crc) begin
      errors++;
      if (errors <= 10) begin
        $display("verdict %0d expected: valid=%0b reason=%0d lba=%h count=%h",
                 compared, want.header_valid, want.fail_reason, want.array_lba,
                 want.entry_count);
        $display("  expected stride=%h crc=%h", want.entry_stride, want.array_crc);
        $display("verdict %0d actual:   valid=%0b reason=%0d lba=%h count=%h",
                 compared, got.header_valid, got.fail_reason, got.array_lba,
                 got.entry_count);
        $display("  actual   stride=%h crc=%h", got.entry_stride, got.array_crc);
      end
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // run limit, far above the slowest legal run
  localparam int unsigned LIMIT       = 100_000;
  // long receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 600;

  // shapes of generated header blocks
  typedef enum int {
    BLK_GOOD, BLK_BAD_SIG, BLK_BAD_SIZE, BLK_BAD_LBA, BLK_BAD_CRC,
    BLK_BAD_STRIDE, BLK_BAD_COUNT, BLK_CUT, BLK_NOISE
  } blk_kind_t;

  // receiver stall behaviors
  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [gpv_pkg::APB_ADDR_W-1:0] paddr;
  logic [gpv_pkg::APB_DATA_W-1:0] pwdata;
  logic [gpv_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           hold_ask;

  gpv_stream_if #(.payload_t(gpv_pkg::in_item_t)) byte_ch ();
  gpv_stream_if #(.payload_t(gpv_pkg::result_t))  verdict_ch ();

  gpt_header_validator_top dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .verdict (verdict_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  header_verdicts board = new();

  logic [7:0]  blk[$];          // bytes of the block about to be streamed
  int unsigned burst_left = 0;  // beats left in the current sender burst
  int unsigned bytes_sent = 0;
  int unsigned blocks_sent = 0;
  int unsigned random_blocks = 0;
  int unsigned settings_used = 1;

  // ---------------------------------------------------------------------------
  // byte sender: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input bit last);
    gpv_pkg::in_item_t it;
    int unsigned       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 48);
    end
    burst_left--;
    it.data_byte = b;
    it.last_byte = last;
    byte_ch.valid   <= 1'b1;
    byte_ch.payload <= it;
    do @(posedge clk); while (!byte_ch.ready);
    board.take_byte(it);
  endtask

  task automatic send_block();
    for (int unsigned i = 0; i < blk.size(); i++) send_beat(blk[i], i == blk.size() - 1);
    bytes_sent += blk.size();
    blocks_sent++;
  endtask

  // wait for every owed verdict, then let the pipeline empty out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.verdicts_owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready, then back to idle
  task automatic reg_write(input gpv_pkg::reg_idx_t idx, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // block builder
  // ---------------------------------------------------------------------------
  function automatic void poke(input logic [12:0] off, input logic [63:0] v,
                               input int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      if (off + k < blk.size()) blk[off + k] = v[8*k +: 8];
  endfunction

  function automatic int unsigned size_limit();
    return (board.cfg_sector_bytes < gpv_pkg::MAX_BLOCK_BYTES) ? board.cfg_sector_bytes
                                                               : gpv_pkg::MAX_BLOCK_BYTES;
  endfunction

  // a header with consistent fields and checksum, then one thing broken according to
  // kind (nothing for a good block); noise blocks are random bytes
  task automatic build_block(input blk_kind_t kind, input int unsigned hsize,
                             input int unsigned blen);
    logic [31:0] hfield;
    logic [31:0] c;
    logic [63:0] lba;
    logic [31:0] stride;
    logic [31:0] count;
    int unsigned span;
    int unsigned pos;
    blk.delete();
    repeat (blen) blk.push_back(8'($urandom));
    if (kind == BLK_NOISE) begin
      // some noise starts like a real header
      if ($urandom_range(0, 3) == 0) poke(13'd0, {gpv_pkg::SIG_HI, gpv_pkg::SIG_LO}, 8);
      return;
    end
    hfield = hsize;
    lba    = board.cfg_lba;
    case ($urandom_range(0, 3))
      0: stride = gpv_pkg::MIN_STRIDE;
      1: stride = gpv_pkg::MAX_ENTRY_BYTES;
      default: stride = $urandom_range(gpv_pkg::MIN_STRIDE, gpv_pkg::MAX_ENTRY_BYTES);
    endcase
    case ($urandom_range(0, 3))
      0: count = 1;
      1: count = gpv_pkg::MAX_ENTRIES;
      default: count = $urandom_range(1, gpv_pkg::MAX_ENTRIES);
    endcase
    case (kind)
      BLK_BAD_SIZE: begin
        case ($urandom_range(0, 3))
          0: hfield = gpv_pkg::MIN_HEADER - 1;
          1: hfield = $urandom_range(0, gpv_pkg::MIN_HEADER - 1);
          2: hfield = size_limit() + 1 + $urandom_range(0, 64);
          default: hfield = $urandom | 32'h8000_0000;
        endcase
      end
      BLK_BAD_LBA: lba = lba ^ (64'd1 << $urandom_range(0, 63));
      BLK_BAD_STRIDE: begin
        case ($urandom_range(0, 3))
          0: stride = gpv_pkg::MIN_STRIDE - 1;
          1: stride = $urandom_range(0, gpv_pkg::MIN_STRIDE - 1);
          2: stride = gpv_pkg::MAX_ENTRY_BYTES + 1 + $urandom_range(0, 100000);
          default: stride = 32'hFFFF_FFFF;
        endcase
      end
      BLK_BAD_COUNT: begin
        case ($urandom_range(0, 3))
          0: count = 0;
          1: count = gpv_pkg::MAX_ENTRIES + 1;
          2: count = gpv_pkg::MAX_ENTRIES + 1 + $urandom_range(0, 100000);
          default: count = 32'hFFFF_FFFF;
        endcase
      end
      default: ;
    endcase
    poke(13'd0, {gpv_pkg::SIG_HI, gpv_pkg::SIG_LO}, 8);
    poke(gpv_pkg::OFF_HSIZE, 64'(hfield), 4);
    poke(gpv_pkg::OFF_HCRC, 64'd0, 4);
    poke(gpv_pkg::OFF_MYLBA, lba, 8);
    poke(gpv_pkg::OFF_ELBA, {$urandom, $urandom}, 8);
    poke(gpv_pkg::OFF_ECOUNT, 64'(count), 4);
    poke(gpv_pkg::OFF_ESIZE, 64'(stride), 4);
    poke(gpv_pkg::OFF_ECRC, 64'($urandom), 4);
    if (kind == BLK_BAD_SIG) begin
      pos = $urandom_range(0, 7);
      blk[pos] = blk[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    span = (hfield > 20) ? hfield : 20;
    if (span > blen) span = blen;
    c = 32'hFFFF_FFFF;
    for (int unsigned i = 0; i < span; i++) c = gpv_pkg::crc_step(c, blk[i]);
    c = ~c;
    if (kind == BLK_BAD_CRC) c = c ^ (32'd1 << $urandom_range(0, 31));
    poke(gpv_pkg::OFF_HCRC, 64'(c), 4);
    // truncated block: the last byte comes early, anywhere in the block
    if (kind == BLK_CUT) begin
      pos = $urandom_range(1, blen - 1);
      while (blk.size() > pos) void'(blk.pop_back());
    end
  endtask

  // random blocks of every shape, good ones the most common, until both floors of the phase are met
  task automatic run_random(input int unsigned min_bytes, input int unsigned min_blocks);
    int unsigned b0;
    int unsigned k0;
    int unsigned lim;
    int unsigned hsize;
    int unsigned blen;
    int unsigned roll;
    blk_kind_t   kind;
    b0 = bytes_sent;
    k0 = blocks_sent;
    while (bytes_sent - b0 < min_bytes || blocks_sent - k0 < min_blocks) begin
      // first few blocks walk through every shape once
      if (random_blocks <= BLK_NOISE) kind = blk_kind_t'(random_blocks);
      else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) kind = BLK_GOOD;
        else if (roll < 45) kind = BLK_BAD_SIG;
        else if (roll < 53) kind = BLK_BAD_SIZE;
        else if (roll < 61) kind = BLK_BAD_LBA;
        else if (roll < 69) kind = BLK_BAD_CRC;
        else if (roll < 77) kind = BLK_BAD_STRIDE;
        else if (roll < 85) kind = BLK_BAD_COUNT;
        else if (roll < 93) kind = BLK_CUT;
        else kind = BLK_NOISE;
      end
      random_blocks++;
      lim   = size_limit();
      hsize = gpv_pkg::MIN_HEADER;
      if (lim > gpv_pkg::MIN_HEADER && $urandom_range(0, 4) == 0)
        hsize = $urandom_range(gpv_pkg::MIN_HEADER + 1, (lim < 300) ? lim : 300);
      blen = (kind == BLK_NOISE) ? $urandom_range(1, 40) : hsize + $urandom_range(0, 20);
      build_block(kind, hsize, blen);
      send_block();
    end
  endtask

  // ---------------------------------------------------------------------------
  // verdict receiver: checks every accepted beat, stalls on its own pattern,
  // and once holds off for a long stretch when asked
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    bit          hold_taken;
    bit          rdy;
    mode       = RX_OPEN;
    mode_left  = 0;
    hold_left  = 0;
    tick       = 0;
    hold_taken = 1'b0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && verdict_ch.valid && verdict_ch.ready) board.check_verdict(verdict_ch.payload);
      tick++;
      if (hold_ask && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:    rdy = 1'b1;
          RX_COIN:    rdy = ($urandom_range(0, 1) != 0);
          RX_PATTERN: rdy = (tick % 5) < 2;
          default:    rdy = $urandom_range(0, 7) != 0;
        endcase
      end
      verdict_ch.ready <= rdy;
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [12:0] bs_set[6];
    logic [63:0] lba_set[6];
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    hold_ask        <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.payload <= '0;

    // register settings per phase: both ends of the sector size, sizes below
    // the minimum header, lba at zero, all ones and random
    bs_set  = '{13'd92, 13'd4096, 13'h1FFF, 13'd91, 13'd0,
                13'($urandom_range(93, 1024))};
    lba_set = '{64'd0, '1, {$urandom, $urandom}, {$urandom, $urandom}, 64'd1,
                {$urandom, $urandom}};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: single-byte block, signature cut one short,
    // bare signature with no header size, all-ones noise
    blk = '{8'h00};
    send_block();
    blk = '{8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52};
    send_block();
    blk = '{8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54};
    send_block();
    blk = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_block();
    drain();

    for (int p = 0; p < 6; p++) begin
      reg_write(gpv_pkg::REG_SECTOR_BYTES, 64'(bs_set[p]));
      reg_write(gpv_pkg::REG_EXPECTED_LBA, lba_set[p]);
      settings_used++;
      case (p)
        0: begin
          // receiver goes deaf while tiny blocks pile verdicts up behind it
          hold_ask <= 1'b1;
          repeat (30) begin
            build_block(BLK_NOISE, 0, $urandom_range(1, 4));
            send_block();
          end
        end
        default: ;
      endcase
      run_random(170, 2);
      drain();
    end

    repeat (8) @(posedge clk);
    if (board.verdicts_owed.size() != 0) begin
      $display("%0d verdicts never arrived", board.verdicts_owed.size());
      board.errors++;
    end
    $display("streamed %0d bytes in %0d blocks under %0d register settings, %0d verdicts",
             bytes_sent, blocks_sent, settings_used, board.compared);
    $display("verdicts by reason: ok %0d sig %0d size %0d lba %0d crc %0d stride %0d count %0d",
             board.by_reason[gpv_pkg::FAIL_NONE], board.by_reason[gpv_pkg::FAIL_SIGNATURE],
             board.by_reason[gpv_pkg::FAIL_SIZE], board.by_reason[gpv_pkg::FAIL_LBA],
             board.by_reason[gpv_pkg::FAIL_CHECKSUM], board.by_reason[gpv_pkg::FAIL_STRIDE],
             board.by_reason[gpv_pkg::FAIL_COUNT]);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
